[rtl/pba_pkg.sv]
// ----------------------------------------------------------------------------
// pba_pkg
// Types and constants shared by the page bitmap allocator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pba_pkg;

    localparam int PAGE_W    = 20;
    localparam int CNT_W     = 24;   // page count of the largest size at the smallest page
    localparam int ROW_BITS  = 64;   // bitmap bits per memory row
    localparam int ROW_SEL_W = 6;
    localparam logic [PAGE_W-1:0] LIMIT_RESET = 20'd4096;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_RESERVE = 2'd1,
        OP_FREE    = 2'd2,
        OP_INIT    = 2'd3
    } pba_op_t;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_EXHAUSTED = 3'd1,
        STAT_WINDOW    = 3'd2,
        STAT_RESERVED  = 3'd3,
        STAT_FREE      = 3'd4,
        STAT_MAPSIZE   = 3'd5
    } pba_status_t;

    typedef enum logic {
        CFG_BASE_PAGE  = 1'b0,
        CFG_LIMIT_PAGE = 1'b1
    } pba_cfg_idx_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RANGE_CHK,
        ST_ALLOC_CHK,
        ST_INIT_CHK,
        ST_RD,
        ST_MOD,
        ST_DONE
    } pba_state_t;

    typedef struct packed {
        logic [1:0]        op;
        logic [PAGE_W-1:0] first_page;
        logic [PAGE_W-1:0] last_page;
        logic [31:0]       size_bytes;
    } pba_in_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [PAGE_W-1:0] page;
    } pba_out_t;

    typedef struct packed {
        pba_op_t           op;
        logic [PAGE_W-1:0] first;
        logic [PAGE_W-1:0] last;
        logic [CNT_W-1:0]  npages;
        logic [PAGE_W:0]   past;     // page just past the map (init)
    } pba_cmd_t;

endpackage

`default_nettype wire

[rtl/pba_front.sv]
// ----------------------------------------------------------------------------
// pba_front
// Decodes an incoming transaction: page count for alloc, map extent for init.
// ----------------------------------------------------------------------------
`default_nettype none

module pba_front import pba_pkg::*; #(
    parameter int PAGE_SHIFT = 12
) (
    input  pba_in_t           item,
    input  logic [PAGE_W-1:0] base_page,
    input  logic [PAGE_W-1:0] limit_page,
    output pba_cmd_t          cmd
);

    localparam int MAP_SHIFT = PAGE_SHIFT - 3;
    localparam logic [32:0] PAGE_ROUND = (33'd1 << PAGE_SHIFT) - 33'd1;
    localparam logic [15:0] MAP_ROUND  = (16'd1 << MAP_SHIFT) - 16'd1;

    logic [32:0]       size_sum;
    logic [PAGE_W-1:0] win;
    logic [PAGE_W:0]   win_sum;
    logic [15:0]       map_sum;
    logic [15:0]       map_pages;

    // map bytes are ceil(win/64)*8, so map pages are ceil(ceil(win/64) / 2^(shift-3))
    always_comb begin
        size_sum  = {1'b0, item.size_bytes} + PAGE_ROUND;
        win       = (limit_page > base_page) ? (limit_page - base_page) : '0;
        win_sum   = {1'b0, win} + 21'd63;
        map_sum   = {1'b0, win_sum[PAGE_W:ROW_SEL_W]} + MAP_ROUND;
        map_pages = map_sum >> MAP_SHIFT;

        cmd.op     = pba_op_t'(item.op);
        cmd.first  = item.first_page;
        cmd.last   = item.last_page;
        cmd.npages = CNT_W'(size_sum >> PAGE_SHIFT);
        cmd.past   = {1'b0, item.first_page} + 21'(map_pages);
    end

endmodule

`default_nettype wire

[rtl/pba_queue.sv]
// ----------------------------------------------------------------------------
// pba_queue
// Two-entry command queue between the decoder and the bitmap sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module pba_queue import pba_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  pba_cmd_t in_cmd,
    output logic     out_valid,
    input  logic     out_ready,
    output pba_cmd_t out_cmd
);

    pba_cmd_t   q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    always_comb begin
        in_ready    = (count_reg != 2'd2);
        out_valid   = (count_reg != 2'd0);
        out_cmd     = q_reg[rd_ptr_reg];
        push        = in_valid & in_ready;
        pop         = out_valid & out_ready;
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

`default_nettype wire

[rtl/pba_back.sv]
// ----------------------------------------------------------------------------
// pba_back
// Bitmap sequencer: clearing sweep, range checks and page-by-page
// read-modify-write of the bitmap memory; holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pba_back import pba_pkg::*; #(
    parameter int PAGES = 4096
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [PAGE_W-1:0] base_page,
    input  logic [PAGE_W-1:0] limit_page,
    input  logic              q_valid,
    output logic              q_ready,
    input  pba_cmd_t          q_cmd,
    output logic              m_valid,
    input  logic              m_ready,
    output pba_out_t          m_item,
    output logic              boot_sweep
);

    localparam int ROWS  = (PAGES + ROW_BITS - 1) / ROW_BITS;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(ROWS - 1);
    localparam logic [PAGE_W:0]   PAGE_LIMIT = 21'(PAGES);

    logic [ROW_BITS-1:0] mem [ROWS];
    logic [ROW_BITS-1:0] rd_data_reg;

    pba_state_t        state_reg, state_next;
    logic              clr_init_reg, clr_init_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [PAGE_W-1:0] next_page_reg, next_page_next;
    logic              m_valid_reg, m_valid_next;
    pba_out_t          m_item_reg, m_item_next;

    pba_op_t           op_reg, op_next;
    logic [PAGE_W-1:0] first_reg, first_next;
    logic [PAGE_W-1:0] last_reg, last_next;
    logic [CNT_W-1:0]  npages_reg, npages_next;
    logic [PAGE_W:0]   past_reg, past_next;
    logic [PAGE_W-1:0] cur_reg, cur_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [PAGE_W-1:0] idx_reg, idx_next;
    logic              has_bit_reg, has_bit_next;
    pba_status_t       res_status_reg, res_status_next;
    logic [PAGE_W-1:0] res_page_reg, res_page_next;

    logic                mem_we;
    logic [ROW_W-1:0]    mem_waddr;
    logic [ROW_BITS-1:0] mem_wdata;
    logic [ROW_W-1:0]    rd_addr;
    logic [PAGE_W-1:0]   diff;
    logic [ROW_BITS-1:0] bit_mask;
    logic                old_bit, taken, freed;
    logic [CNT_W:0]      alloc_end;

    always_comb begin
        state_next      = state_reg;
        clr_init_next   = clr_init_reg;
        row_next        = row_reg;
        next_page_next  = next_page_reg;
        m_valid_next    = m_valid_reg & ~m_ready;
        m_item_next     = m_item_reg;
        op_next         = op_reg;
        first_next      = first_reg;
        last_next       = last_reg;
        npages_next     = npages_reg;
        past_next       = past_reg;
        cur_next        = cur_reg;
        rem_next        = rem_reg;
        idx_next        = idx_reg;
        has_bit_next    = has_bit_reg;
        res_status_next = res_status_reg;
        res_page_next   = res_page_reg;
        q_ready         = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = row_reg;
        mem_wdata       = '0;

        diff      = cur_reg - base_page;
        rd_addr   = ROW_W'(diff >> ROW_SEL_W);
        bit_mask  = {{(ROW_BITS-1){1'b0}}, 1'b1} << idx_reg[ROW_SEL_W-1:0];
        old_bit   = rd_data_reg[idx_reg[ROW_SEL_W-1:0]];
        taken     = ~has_bit_reg | old_bit;
        freed     = ~has_bit_reg | ~old_bit;
        alloc_end = (CNT_W+1)'(next_page_reg) + (CNT_W+1)'(npages_reg);

        unique case (state_reg)
            ST_CLEAR: begin
                mem_we = 1'b1;
                if (row_reg == LAST_ROW) begin
                    row_next      = '0;
                    clr_init_next = 1'b0;
                    state_next    = clr_init_reg ? ST_INIT_CHK : ST_IDLE;
                end else begin
                    row_next = row_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                q_ready = 1'b1;
                if (q_valid) begin
                    op_next     = q_cmd.op;
                    first_next  = q_cmd.first;
                    last_next   = q_cmd.last;
                    npages_next = q_cmd.npages;
                    past_next   = q_cmd.past;
                    unique case (q_cmd.op)
                        OP_ALLOC: begin
                            state_next = ST_ALLOC_CHK;
                        end
                        OP_RESERVE, OP_FREE: begin
                            state_next = ST_RANGE_CHK;
                        end
                        OP_INIT: begin
                            clr_init_next = 1'b1;
                            state_next    = ST_CLEAR;
                        end
                    endcase
                end
            end
            ST_RANGE_CHK: begin
                if (last_reg < first_reg || first_reg < base_page || last_reg >= limit_page) begin
                    res_status_next = STAT_WINDOW;
                    res_page_next   = next_page_reg;
                    state_next      = ST_DONE;
                end else begin
                    cur_next   = first_reg;
                    state_next = ST_RD;
                end
            end
            ST_ALLOC_CHK: begin
                res_page_next = next_page_reg;
                if (alloc_end >= (CNT_W+1)'(limit_page)) begin
                    res_status_next = STAT_EXHAUSTED;
                    state_next      = ST_DONE;
                end else if (npages_reg == '0) begin
                    res_status_next = STAT_OK;
                    state_next      = ST_DONE;
                end else begin
                    cur_next   = next_page_reg;
                    rem_next   = npages_reg;
                    state_next = ST_RD;
                end
            end
            ST_INIT_CHK: begin
                next_page_next = past_reg[PAGE_W-1:0];
                res_page_next  = past_reg[PAGE_W-1:0];
                if (past_reg >= {1'b0, limit_page}) begin
                    res_status_next = STAT_MAPSIZE;
                    state_next      = ST_DONE;
                end else if (past_reg == '0) begin
                    res_status_next = STAT_WINDOW;
                    state_next      = ST_DONE;
                end else begin
                    last_next  = past_reg[PAGE_W-1:0] - 1'b1;
                    state_next = ST_RANGE_CHK;
                end
            end
            ST_RD: begin
                idx_next     = diff;
                has_bit_next = (cur_reg >= base_page) && ({1'b0, diff} < PAGE_LIMIT);
                state_next   = ST_MOD;
            end
            ST_MOD: begin
                mem_we    = has_bit_reg;
                mem_waddr = ROW_W'(idx_reg >> ROW_SEL_W);
                mem_wdata = (op_reg == OP_FREE) ? (rd_data_reg & ~bit_mask)
                                                : (rd_data_reg | bit_mask);
                unique case (op_reg)
                    OP_ALLOC: begin
                        if (taken) begin
                            next_page_next = cur_reg + 1'b1;
                            state_next     = ST_ALLOC_CHK;
                        end else if (rem_reg == CNT_W'(1)) begin
                            res_status_next = STAT_OK;
                            res_page_next   = next_page_reg;
                            next_page_next  = cur_reg + 1'b1;
                            state_next      = ST_DONE;
                        end else begin
                            cur_next   = cur_reg + 1'b1;
                            rem_next   = rem_reg - 1'b1;
                            state_next = ST_RD;
                        end
                    end
                    OP_FREE: begin
                        res_page_next = next_page_reg;
                        if (freed) begin
                            res_status_next = STAT_FREE;
                            state_next      = ST_DONE;
                        end else if (cur_reg == last_reg) begin
                            res_status_next = STAT_OK;
                            state_next      = ST_DONE;
                        end else begin
                            cur_next   = cur_reg + 1'b1;
                            state_next = ST_RD;
                        end
                    end
                    OP_RESERVE, OP_INIT: begin
                        res_page_next = next_page_reg;
                        if (taken) begin
                            res_status_next = STAT_RESERVED;
                            state_next      = ST_DONE;
                        end else if (cur_reg == last_reg) begin
                            res_status_next = STAT_OK;
                            state_next      = ST_DONE;
                        end else begin
                            cur_next   = cur_reg + 1'b1;
                            state_next = ST_RD;
                        end
                    end
                endcase
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next       = 1'b1;
                    m_item_next.status = res_status_reg;
                    m_item_next.page   = res_page_reg;
                    state_next         = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_init_reg  <= 1'b0;
            row_reg       <= '0;
            next_page_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_init_reg  <= clr_init_next;
            row_reg       <= row_next;
            next_page_reg <= next_page_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_item_reg     <= m_item_next;
        op_reg         <= op_next;
        first_reg      <= first_next;
        last_reg       <= last_next;
        npages_reg     <= npages_next;
        past_reg       <= past_next;
        cur_reg        <= cur_next;
        rem_reg        <= rem_next;
        idx_reg        <= idx_next;
        has_bit_reg    <= has_bit_next;
        res_status_reg <= res_status_next;
        res_page_reg   <= res_page_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign m_valid    = m_valid_reg;
    assign m_item     = m_item_reg;
    assign boot_sweep = (state_reg == ST_CLEAR) && !clr_init_reg;

    a_pop_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_ready |-> state_reg == ST_IDLE)
        else $error("command popped outside idle");

    a_write_states: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == ST_CLEAR || state_reg == ST_MOD))
        else $error("bitmap written outside sweep or modify");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised without a finished command");

    a_ptr_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(next_page_reg) |-> $past(state_reg == ST_MOD || state_reg == ST_INIT_CHK))
        else $error("next page pointer changed outside modify or init");

    a_read_then_mod: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_RD |=> state_reg == ST_MOD)
        else $error("read not followed by modify");

endmodule

`default_nettype wire

[rtl/page_bitmap_allocator.sv]
// ----------------------------------------------------------------------------
// page_bitmap_allocator
// One-bit-per-page allocator over a configurable page window with a
// next-page pointer: alloc, reserve range, free range and init.
//
//   channel   dir   handshake         payload
//   cfg       in    cfg_we            cfg_index, cfg_data
//   s_        in    s_valid/s_ready   s_item  (pba_in_t)
//   m_        out   m_valid/m_ready   m_item  (pba_out_t)
//
// Reserve/free: a range check, then a read and a modify per page walked; alloc:
// a check per try, then a read and a modify per page probed; init runs the
// clearing sweep over ROWS = ceil(PAGES/64) rows, then a reserve of its map pages.
// Each page costs a read and a write of its bitmap row.
// After reset a clearing sweep over all ROWS rows runs with s_ready low.
// A two-entry queue takes new transactions while one is in work or a
// result waits on m_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module page_bitmap_allocator import pba_pkg::*; #(
    parameter int PAGES      = 4096,
    parameter int PAGE_SHIFT = 12
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [0:0]        cfg_index,
    input  logic [PAGE_W-1:0] cfg_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  pba_in_t           s_item,
    output logic              m_valid,
    input  logic              m_ready,
    output pba_out_t          m_item
);

    logic [PAGE_W-1:0] base_page_reg;
    logic [PAGE_W-1:0] limit_page_reg;
    pba_cmd_t          front_cmd;
    pba_cmd_t          head_cmd;
    logic              q_in_ready;
    logic              head_valid;
    logic              head_ready;
    logic              boot_sweep;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_page_reg  <= '0;
            limit_page_reg <= LIMIT_RESET;
        end else if (cfg_we) begin
            unique case (pba_cfg_idx_t'(cfg_index))
                CFG_BASE_PAGE:  base_page_reg  <= cfg_data;
                CFG_LIMIT_PAGE: limit_page_reg <= cfg_data;
            endcase
        end
    end

    assign s_ready = q_in_ready & ~boot_sweep;

    pba_front #(
        .PAGE_SHIFT(PAGE_SHIFT)
    ) u_front (
        .item      (s_item),
        .base_page (base_page_reg),
        .limit_page(limit_page_reg),
        .cmd       (front_cmd)
    );

    pba_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid & ~boot_sweep),
        .in_ready (q_in_ready),
        .in_cmd   (front_cmd),
        .out_valid(head_valid),
        .out_ready(head_ready),
        .out_cmd  (head_cmd)
    );

    pba_back #(
        .PAGES(PAGES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .base_page (base_page_reg),
        .limit_page(limit_page_reg),
        .q_valid   (head_valid),
        .q_ready   (head_ready),
        .q_cmd     (head_cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .boot_sweep(boot_sweep)
    );

endmodule

`default_nettype wire

[sim/tb_page_bitmap_allocator.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_page_bitmap_allocator
// Self-checking bench for the page bitmap allocator. A behavioral copy of the
// bitmap and next-page pointer predicts status and page for each accepted
// transaction. Directed tasks cover the bounds, partial failures, the map
// cases and the window extremes. Random phases over several window settings
// follow, then an output stall that backs up the input and a full-rate tail.
// ----------------------------------------------------------------------------
module tb_page_bitmap_allocator import pba_pkg::*;;

    localparam int              CLK_PERIOD = 12;
    localparam int              NPAGES     = 4096;
    localparam int              PSHIFT     = 12;
    localparam longint unsigned PG_BYTES   = 64'd1 << PSHIFT;
    localparam longint unsigned MAP_ALIGN  = 8;
    localparam longint unsigned PAGE_MASK  = 64'hFFFFF;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              cfg_we;
    logic [0:0]        cfg_index;
    logic [PAGE_W-1:0] cfg_data;
    logic              s_valid;
    logic              s_ready;
    pba_in_t           s_item;
    logic              m_valid;
    logic              m_ready;
    pba_out_t          m_item;

    page_bitmap_allocator #(
        .PAGES      (NPAGES),
        .PAGE_SHIFT (PSHIFT)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // behavioral bitmap state
    bit              bm [NPAGES];
    longint unsigned bm_base;
    longint unsigned bm_limit;
    longint unsigned bm_next;

    pba_out_t status_page_q [$];
    int       fail_cnt;
    bit       src_idle;
    bit       sink_idle;
    int       hold_cnt;

    function automatic bit claim_page(longint unsigned pg);
        bit was;
        if (pg < bm_base || pg - bm_base >= NPAGES) return 1'b1;
        was = bm[pg - bm_base];
        bm[pg - bm_base] = 1'b1;
        return was;
    endfunction

    function automatic bit release_page(longint unsigned pg);
        bit was;
        if (pg < bm_base || pg - bm_base >= NPAGES) return 1'b0;
        was = bm[pg - bm_base];
        bm[pg - bm_base] = 1'b0;
        return was;
    endfunction

    function automatic pba_status_t mark_span(longint unsigned first, longint unsigned last,
                                              bit set);
        longint unsigned p;
        if (last < first || first < bm_base || last >= bm_limit) return STAT_WINDOW;
        for (p = first; p <= last; p++) begin
            if (set) begin
                if (claim_page(p)) return STAT_RESERVED;
            end else if (!release_page(p)) begin
                return STAT_FREE;
            end
        end
        return STAT_OK;
    endfunction

    function automatic pba_status_t claim_run(longint unsigned size,
                                              output longint unsigned start);
        longint unsigned cnt;
        longint unsigned i;
        bit              again;
        cnt   = (size + PG_BYTES - 1) >> PSHIFT;
        start = bm_next;
        again = 1'b1;
        while (again) begin
            again = 1'b0;
            if (bm_next + cnt >= bm_limit) return STAT_EXHAUSTED;
            for (i = 0; i < cnt; i++) begin
                if (claim_page(bm_next + i)) begin
                    bm_next += i + 1;
                    again = 1'b1;
                    break;
                end
            end
        end
        start = bm_next;
        bm_next += cnt;
        return STAT_OK;
    endfunction

    function automatic pba_status_t init_map(longint unsigned map_pg);
        longint unsigned win;
        longint unsigned bytes;
        longint unsigned mpages;
        longint unsigned past;
        win    = (bm_limit > bm_base) ? bm_limit - bm_base : 0;
        bytes  = (win + 7) / 8;
        bytes  = (bytes + MAP_ALIGN - 1) / MAP_ALIGN * MAP_ALIGN;
        mpages = (bytes + PG_BYTES - 1) >> PSHIFT;
        foreach (bm[k]) bm[k] = 1'b0;
        past    = map_pg + mpages;
        bm_next = past & PAGE_MASK;
        if (past >= bm_limit) return STAT_MAPSIZE;
        if (past == 0) return STAT_WINDOW;
        return mark_span(map_pg, past - 1, 1'b1);
    endfunction

    function automatic pba_out_t run_bitmap_op(pba_in_t it);
        pba_out_t        r;
        pba_status_t     st;
        longint unsigned start;
        start = 0;
        case (pba_op_t'(it.op))
            OP_ALLOC:   st = claim_run(it.size_bytes, start);
            OP_RESERVE: st = mark_span(it.first_page, it.last_page, 1'b1);
            OP_FREE:    st = mark_span(it.first_page, it.last_page, 1'b0);
            default:    st = init_map(it.first_page);
        endcase
        r.status = st;
        r.page   = (it.op == OP_ALLOC && st == STAT_OK) ? PAGE_W'(start) : PAGE_W'(bm_next);
        return r;
    endfunction

    function automatic pba_in_t mk_op(pba_op_t op, logic [PAGE_W-1:0] first,
                                      logic [PAGE_W-1:0] last, logic [31:0] size);
        pba_in_t it;
        it.op         = op;
        it.first_page = first;
        it.last_page  = last;
        it.size_bytes = size;
        return it;
    endfunction

    // mostly well-formed ops around the window and the pointer, some noise
    function automatic pba_in_t rand_op();
        pba_in_t         it;
        int unsigned     pick;
        int unsigned     span;
        longint unsigned win;
        longint unsigned anchor;
        win = (bm_limit > bm_base) ? bm_limit - bm_base : 1;
        if (win > NPAGES + 256) win = NPAGES + 256;
        it.op         = 2'($urandom_range(0, 3));
        it.first_page = PAGE_W'($urandom);
        it.last_page  = PAGE_W'($urandom);
        it.size_bytes = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            // keep the pointer near the window so alloc walks stay short
            if (it.op == OP_INIT && (it.first_page + 64 < bm_base || it.first_page > 20'hFFFE0))
                it.first_page = PAGE_W'(bm_base);
        end else if (pick < 45) begin
            it.op = OP_ALLOC;
            case ($urandom_range(0, 9))
                0:       it.size_bytes = '0;
                1:       it.size_bytes = $urandom;
                2, 3:    it.size_bytes = $urandom_range(1, 32'(64 * PG_BYTES));
                default: it.size_bytes = $urandom_range(1, 32'(8 * PG_BYTES));
            endcase
        end else if (pick < 92) begin
            it.op = (pick < 70) ? OP_RESERVE : OP_FREE;
            case ($urandom_range(0, 3))
                0:       anchor = bm_base + $urandom_range(0, 32'(win - 1));
                1:       anchor = (bm_base >= 4) ? bm_base - $urandom_range(0, 4) : bm_base;
                default: anchor = (bm_next >= 16) ? bm_next - $urandom_range(0, 16) : bm_next;
            endcase
            span = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 12);
            it.first_page = PAGE_W'(anchor);
            if ($urandom_range(0, 19) == 0) it.last_page = PAGE_W'(it.first_page - 1);
            else it.last_page = PAGE_W'(anchor + span);
        end else begin
            it.op = OP_INIT;
            case ($urandom_range(0, 7))
                0:       it.first_page = (bm_base >= 40) ?
                                         PAGE_W'(bm_base - $urandom_range(1, 40)) :
                                         PAGE_W'(bm_base);
                1:       it.first_page = PAGE_W'(20'hFFFFF - $urandom_range(1, 40));
                default: it.first_page = PAGE_W'(bm_base + $urandom_range(0, 8));
            endcase
        end
        return it;
    endfunction

    task automatic send_item(input pba_in_t it);
        int gap;
        @(negedge aclk);
        gap = (src_idle && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        status_page_q.push_back(run_bitmap_op(it));
    endtask

    task automatic wait_drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (status_page_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_window(input logic [PAGE_W-1:0] base, input logic [PAGE_W-1:0] limit);
        wait_drain();
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_BASE_PAGE;
        cfg_data  <= base;
        @(negedge aclk);
        cfg_index <= CFG_LIMIT_PAGE;
        cfg_data  <= limit;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        bm_base  = base;
        bm_limit = limit;
    endtask

    // reset window, pointer at zero, no init yet
    task automatic test_before_init();
        send_item(mk_op(OP_ALLOC,   20'd0,  20'd0,  32'd0));
        send_item(mk_op(OP_ALLOC,   20'd0,  20'd0,  32'd1));
        send_item(mk_op(OP_ALLOC,   20'd0,  20'd0,  32'd4097));
        send_item(mk_op(OP_RESERVE, 20'd10, 20'd12, 32'd0));
        send_item(mk_op(OP_RESERVE, 20'd12, 20'd13, 32'd0));
        send_item(mk_op(OP_FREE,    20'd11, 20'd14, 32'd0));
        send_item(mk_op(OP_RESERVE, 20'd5,  20'd4,  32'd0));
        // runs into page 10 and retries past it
        send_item(mk_op(OP_ALLOC,   20'd0,  20'd0,  32'd32768));
        send_item(mk_op(OP_ALLOC,   20'd0,  20'd0,  32'hFFFFFFFF));
        send_item(mk_op(OP_FREE,    20'd3,  20'd9,  32'd0));
        wait_drain();
    endtask

    task automatic test_init_cases();
        send_item(mk_op(OP_INIT,    20'd0,       20'd0,       32'd0));
        send_item(mk_op(OP_ALLOC,   20'd0,       20'd0,       32'd0));
        send_item(mk_op(OP_ALLOC,   20'd0,       20'd0,       32'd16773120));
        send_item(mk_op(OP_INIT,    20'd4095,    20'd0,       32'd0));
        send_item(mk_op(OP_ALLOC,   20'd0,       20'd0,       32'd0));
        send_item(mk_op(OP_FREE,    20'd0,       20'd0,       32'd0));
        send_item(mk_op(OP_RESERVE, 20'hFFFFF,   20'hFFFFF,   32'd0));
        wait_drain();
    endtask

    task automatic test_window_extremes();
        set_window(20'd100, 20'd50);
        send_item(mk_op(OP_INIT,    20'd0,     20'd0,     32'd0));
        set_window(20'd0, 20'd0);
        send_item(mk_op(OP_INIT,    20'd5,     20'd0,     32'd0));
        set_window(20'hFFFFF, 20'hFFFFF);
        send_item(mk_op(OP_INIT,    20'hFFFFF, 20'd0,     32'd0));
        send_item(mk_op(OP_RESERVE, 20'hFFFFF, 20'hFFFFF, 32'd0));
        set_window(20'd0, 20'hFFFFF);
        send_item(mk_op(OP_INIT,    20'd0,     20'd0,     32'd0));
        send_item(mk_op(OP_RESERVE, 20'd4095,  20'd4097,  32'd0));
        send_item(mk_op(OP_FREE,    20'd4096,  20'd4096,  32'd0));
        send_item(mk_op(OP_ALLOC,   20'd0,     20'd0,     32'hFFFFFFFF));
        set_window(20'd1000, 20'd5096);
        send_item(mk_op(OP_RESERVE, 20'd999,   20'd1000,  32'd0));
        send_item(mk_op(OP_INIT,    20'd500,   20'd0,     32'd0));
        // pointer below the window: alloc skips up to the first page with a bit
        send_item(mk_op(OP_ALLOC,   20'd0,     20'd0,     32'd4096));
        wait_drain();
    endtask

    task automatic test_random_window(input logic [PAGE_W-1:0] base,
                                      input logic [PAGE_W-1:0] limit, input int n);
        set_window(base, limit);
        send_item(mk_op(OP_INIT, base, 20'd0, 32'd0));
        repeat (n) send_item(rand_op());
        wait_drain();
    endtask

    task automatic test_output_stall();
        hold_cnt = 150;
        repeat (12) send_item(rand_op());
        wait_drain();
    endtask

    task automatic test_full_rate();
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        repeat (60) send_item(rand_op());
        wait_drain();
    endtask

    // result side ready, with short bursts of backpressure and long holds
    initial begin
        int burst;
        burst   = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_ready <= 1'b0;
            end else if (burst > 0) begin
                burst--;
                m_ready <= 1'b0;
            end else if (sink_idle && $urandom_range(0, 4) == 0) begin
                burst = $urandom_range(0, 2);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        pba_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (status_page_q.size() == 0) begin
                $error("unexpected transaction: status %0d page 0x%0h",
                       m_item.status, m_item.page);
                fail_cnt++;
            end else begin
                want = status_page_q.pop_front();
                if (m_item.status !== want.status) begin
                    $error("status mismatch: expected %0d, actual %0d",
                           want.status, m_item.status);
                    fail_cnt++;
                end
                if (m_item.page !== want.page) begin
                    $error("page mismatch: expected 0x%0h, actual 0x%0h",
                           want.page, m_item.page);
                    fail_cnt++;
                end
            end
        end
    end

    initial begin
        #(CLK_PERIOD * 1_500_000);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int unsigned b;
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_valid   = 1'b0;
        s_item    = '0;
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        hold_cnt  = 0;
        fail_cnt  = 0;
        bm_base   = 0;
        bm_limit  = LIMIT_RESET;
        bm_next   = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        // clearing sweep after reset
        do @(posedge aclk); while (!s_ready);

        test_before_init();
        test_init_cases();
        test_window_extremes();
        test_random_window(20'd0, 20'd4096, 110);
        b = $urandom_range(0, 300);
        test_random_window(PAGE_W'(b), PAGE_W'(b + $urandom_range(64, 600)), 70);
        b = $urandom_range(0, 20'hFE000);
        test_random_window(PAGE_W'(b), PAGE_W'(b + NPAGES + $urandom_range(1, 200)), 70);
        test_random_window(20'hFEFFF, 20'hFFFFF, 50);
        test_output_stall();
        test_full_rate();

        if (fail_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
